/* hw/rtl/owb_pkg.sv */
// Package for the single-wire bus master: command codes, register indexes,
// reset values of the timing registers, phase encoding and result payload type.
// No dependencies.
package owb_pkg;

   // Width of every timing register and of the tick timer
   localparam int unsigned TickWidth = 10;
   localparam int unsigned BitsPerByte = 8;
   localparam int unsigned BitIdxWidth = $clog2(BitsPerByte);

   // Command codes carried by an input beat
   typedef enum logic [1:0] {
      FUNC_NONE  = 2'd0,
      FUNC_RESET = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_READ  = 2'd3
   } func_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_RESET_LOW     = 3'd0,
      REG_PRESENCE_WAIT = 3'd1,
      REG_RESET_REC     = 3'd2,
      REG_SLOT          = 3'd3,
      REG_GAP           = 3'd4,
      REG_SHORT_LOW     = 3'd5
   } reg_index_type;

   // Reset values of the timing registers, in ticks
   localparam logic [TickWidth-1:0] ResetLowDefault      = 10'd480;
   localparam logic [TickWidth-1:0] PresenceWaitDefault  = 10'd60;
   localparam logic [TickWidth-1:0] ResetRecoveryDefault = 10'd480;
   localparam logic [TickWidth-1:0] SlotDefault          = 10'd60;
   localparam logic [TickWidth-1:0] GapDefault           = 10'd2;
   localparam logic [TickWidth-1:0] ShortLowDefault      = 10'd2;

   // Bus phases, one-hot
   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_RST_LOW  = 8'b0000_0010,
      PH_RST_WAIT = 8'b0000_0100,
      PH_RST_REC  = 8'b0000_1000,
      PH_WR_SLOT  = 8'b0001_0000,
      PH_WR_GAP   = 8'b0010_0000,
      PH_RD_LOW   = 8'b0100_0000,
      PH_RD_REST  = 8'b1000_0000
   } phase_type;

   // One result beat
   typedef struct packed {
      logic                   drive_low;
      logic                   busy_res;
      logic                   done_res;
      logic                   presence;
      logic [BitsPerByte-1:0] read_data;
   } rsp_payload_type;

endpackage

/* hw/rtl/owb_req_if.sv */
// Input channel of the single-wire bus master: one beat per bus tick.
// Depends on owb_pkg.
interface owb_req_if
   import owb_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [1:0]             func;
   logic [BitsPerByte-1:0] data;
   logic                   line_level;

   modport source (output valid, output func, output data, output line_level, input ready);
   modport sink   (input valid, input func, input data, input line_level, output ready);
endinterface

/* hw/rtl/owb_rsp_if.sv */
// Result channel of the single-wire bus master: one beat per accepted tick.
// Depends on owb_pkg.
interface owb_rsp_if
   import owb_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   drive_low;
   logic                   busy_res;
   logic                   done_res;
   logic                   presence;
   logic [BitsPerByte-1:0] read_data;

   modport source (output valid, output drive_low, output busy_res, output done_res,
                   output presence, output read_data, input ready);
   modport sink   (input valid, input drive_low, input busy_res, input done_res,
                   input presence, input read_data, output ready);
endinterface

/* hw/rtl/onewire_bus_master.sv */
// Single-wire open-drain bus master, top level.
// Depends on owb_pkg, owb_req_if and owb_rsp_if.
//
// Each input beat is one bus tick: it carries the sampled line level and an
// optional command (reset with presence detect, write a byte, read a byte),
// and produces exactly one result beat telling whether to pull the line low
// this tick, plus busy, done, presence and the last byte read. A command is
// taken only while idle and its first tick is the beat that carries it;
// commands arriving while busy are dropped. The block accepts one beat every
// clock cycle: the whole tick update is one pass of logic from the state
// registers into the result register, so a result appears in the cycle after
// its beat is accepted, and the input stalls only while that result register
// is full and not being taken. Timing registers are to be written over the
// csr_ port only while no command is running; the block does not enforce this.
module onewire_bus_master
   import owb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   owb_req_if.sink              req_if,
   owb_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [TickWidth-1:0] csr_wdata
);

   // Timing registers
   logic [TickWidth-1:0] reset_low_ff, presence_wait_ff, reset_rec_ff;
   logic [TickWidth-1:0] slot_ff, gap_ff, short_low_ff;

   // Engine state
   phase_type              phase_ff, phase_in;
   logic [TickWidth-1:0]   timer_ff, timer_in;
   logic [BitIdxWidth-1:0] bit_ff, bit_in;
   logic [BitsPerByte-1:0] shift_ff, shift_in;
   logic                   presence_ff, presence_in;
   logic [BitsPerByte-1:0] hold_ff, hold_in;

   // Values after a new command has been taken on this tick
   phase_type              st_phase;
   logic [TickWidth-1:0]   st_timer;
   logic [BitIdxWidth-1:0] st_bit;
   logic [BitsPerByte-1:0] st_shift;

   logic drive, busy, done;

   // Result register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic req_fire;

   // True on the last tick of a stage of n ticks; zero acts as one
   function automatic logic stage_ends(input logic [TickWidth-1:0] t,
                                       input logic [TickWidth-1:0] n);
      logic [TickWidth:0] t1;
      t1 = {1'b0, t} + {{TickWidth{1'b0}}, 1'b1};
      return t1 >= {1'b0, n};
   endfunction

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= ResetLowDefault;
         presence_wait_ff <= PresenceWaitDefault;
         reset_rec_ff     <= ResetRecoveryDefault;
         slot_ff          <= SlotDefault;
         gap_ff           <= GapDefault;
         short_low_ff     <= ShortLowDefault;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RESET_LOW:     reset_low_ff     <= csr_wdata;
            REG_PRESENCE_WAIT: presence_wait_ff <= csr_wdata;
            REG_RESET_REC:     reset_rec_ff     <= csr_wdata;
            REG_SLOT:          slot_ff          <= csr_wdata;
            REG_GAP:           gap_ff           <= csr_wdata;
            REG_SHORT_LOW:     short_low_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Command start: a nonzero command is taken only while idle
   always_comb begin
      st_phase = phase_ff;
      st_timer = timer_ff;
      st_bit   = bit_ff;
      st_shift = shift_ff;
      if (phase_ff == PH_IDLE && req_if.func != FUNC_NONE) begin
         st_timer = '0;
         st_bit   = '0;
         unique case (req_if.func)
            FUNC_RESET: st_phase = PH_RST_LOW;
            FUNC_WRITE: begin
               st_shift = req_if.data;
               st_phase = PH_WR_SLOT;
            end
            default: begin
               st_shift = '0;
               st_phase = PH_RD_LOW;
            end
         endcase
      end
   end

   // One tick of the bus engine
   always_comb begin
      phase_in    = st_phase;
      timer_in    = st_timer + 1'b1;
      bit_in      = st_bit;
      shift_in    = st_shift;
      presence_in = presence_ff;
      hold_in     = hold_ff;
      drive       = 1'b0;
      done        = 1'b0;
      busy        = (st_phase != PH_IDLE);

      unique case (st_phase)
         PH_IDLE: begin
            timer_in = st_timer;
         end
         PH_RST_LOW: begin
            drive = 1'b1;
            if (stage_ends(st_timer, reset_low_ff)) begin
               phase_in = PH_RST_WAIT;
               timer_in = '0;
            end
         end
         PH_RST_WAIT: begin
            if (st_timer >= presence_wait_ff) begin
               // Sample tick: a device answering holds the line low
               presence_in = !req_if.line_level;
               timer_in    = '0;
               if (!req_if.line_level && reset_rec_ff != '0) begin
                  phase_in = PH_RST_REC;
               end else begin
                  phase_in = PH_IDLE;
                  bit_in   = '0;
                  done     = 1'b1;
               end
            end
         end
         PH_RST_REC: begin
            if (stage_ends(st_timer, reset_rec_ff)) begin
               phase_in = PH_IDLE;
               timer_in = '0;
               bit_in   = '0;
               done     = 1'b1;
            end
         end
         PH_WR_SLOT: begin
            drive = !st_shift[0] || (st_timer < short_low_ff);
            if (stage_ends(st_timer, slot_ff)) begin
               timer_in = '0;
               if (gap_ff != '0) begin
                  phase_in = PH_WR_GAP;
               end else if (st_bit == BitIdxWidth'(BitsPerByte - 1)) begin
                  phase_in = PH_IDLE;
                  bit_in   = '0;
                  done     = 1'b1;
               end else begin
                  bit_in   = st_bit + 1'b1;
                  shift_in = st_shift >> 1;
               end
            end
         end
         PH_WR_GAP: begin
            if (stage_ends(st_timer, gap_ff)) begin
               timer_in = '0;
               if (st_bit == BitIdxWidth'(BitsPerByte - 1)) begin
                  phase_in = PH_IDLE;
                  bit_in   = '0;
                  done     = 1'b1;
               end else begin
                  bit_in   = st_bit + 1'b1;
                  shift_in = st_shift >> 1;
                  phase_in = PH_WR_SLOT;
               end
            end
         end
         PH_RD_LOW: begin
            drive = 1'b1;
            if (stage_ends(st_timer, short_low_ff)) begin
               phase_in = PH_RD_REST;
               timer_in = '0;
            end
         end
         PH_RD_REST: begin
            // First released tick samples the bit into the top
            if (st_timer == '0) begin
               shift_in = {req_if.line_level, st_shift[BitsPerByte-1:1]};
            end
            if (stage_ends(st_timer, slot_ff)) begin
               timer_in = '0;
               if (st_bit == BitIdxWidth'(BitsPerByte - 1)) begin
                  hold_in  = shift_in;
                  phase_in = PH_IDLE;
                  bit_in   = '0;
                  done     = 1'b1;
               end else begin
                  bit_in   = st_bit + 1'b1;
                  phase_in = PH_RD_LOW;
               end
            end
         end
         default: begin
            // Unreachable code: fall back to idle with the line released
            phase_in = PH_IDLE;
            timer_in = '0;
            bit_in   = '0;
            busy     = 1'b0;
         end
      endcase
   end

   // Result payload of this tick
   always_comb begin
      rsp_in.drive_low = drive;
      rsp_in.busy_res  = busy;
      rsp_in.done_res  = done;
      rsp_in.presence  = presence_in;
      rsp_in.read_data = hold_in;
   end

   // State advances once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         timer_ff    <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         presence_ff <= 1'b0;
         hold_ff     <= '0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         presence_ff <= presence_in;
         hold_ff     <= hold_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.drive_low = rsp_ff.drive_low;
   assign rsp_if.busy_res  = rsp_ff.busy_res;
   assign rsp_if.done_res  = rsp_ff.done_res;
   assign rsp_if.presence  = rsp_ff.presence;
   assign rsp_if.read_data = rsp_ff.read_data;

   // A completing tick always leaves the engine idle
   assert property (@(posedge clock) disable iff (reset)
      req_fire && done |=> phase_ff == PH_IDLE)
      else $error("engine not idle after completing tick");

   // Idle means timer and bit counter are cleared
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> timer_ff == '0 && bit_ff == '0)
      else $error("idle with stale timer or bit index");

   // The line is only pulled low during a command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.drive_low |-> rsp_ff.busy_res)
      else $error("line driven low while not busy");

   // Done is only reported on a busy tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> rsp_ff.busy_res)
      else $error("done without busy");

   // Held read byte changes only on a completing read
   assert property (@(posedge clock) disable iff (reset)
      !(req_fire && done) |=> $stable(hold_ff))
      else $error("read byte changed outside a completing tick");

endmodule

/* test/onewire_bus_master_checker.sv */
// Checker for the single-wire bus master: follows the timing registers, predicts
// the result beat of every accepted tick and compares it with the returned beat.
// Depends on owb_pkg, owb_req_if and owb_rsp_if.
module onewire_bus_master_checker
   import owb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   owb_req_if                   req_mon,
   owb_rsp_if                   rsp_mon,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [TickWidth-1:0] csr_wdata,
   output int unsigned          mismatch_count,
   output int unsigned          pending_count,
   output logic                 bus_idle
);

   // Timing registers as the block should hold them
   logic [TickWidth-1:0] reset_low_len;
   logic [TickWidth-1:0] presence_wait_len;
   logic [TickWidth-1:0] recovery_len;
   logic [TickWidth-1:0] slot_len;
   logic [TickWidth-1:0] gap_len;
   logic [TickWidth-1:0] short_low_len;

   // Predicted bus engine state
   phase_type              bus_phase;
   logic [TickWidth-1:0]   tick_cnt;
   logic [BitIdxWidth-1:0] bit_pos;
   logic [BitsPerByte-1:0] shift_reg;
   logic [BitsPerByte-1:0] read_byte;
   logic                   device_seen;

   // Result beats predicted but not yet returned, oldest first
   rsp_payload_type awaited_beats[$];

   // True on the last tick of a stage lasting len ticks; a zero length acts as one.
   function automatic logic stage_done(logic [TickWidth-1:0] len);
      return int'(tick_cnt) + 1 >= int'(len);
   endfunction

   function automatic void end_command();
      bus_phase = PH_IDLE;
      tick_cnt  = '0;
      bit_pos   = '0;
   endfunction

   // Moves on to the next bit slot; true once the whole byte has gone by.
   function automatic logic next_bit();
      tick_cnt = '0;
      if (bit_pos >= BitsPerByte - 1) begin
         return 1'b1;
      end
      bit_pos = bit_pos + 1'b1;
      return 1'b0;
   endfunction

   // Advances the engine by one tick and returns the result beat it gives.
   function automatic rsp_payload_type bus_tick_outcome(func_type cmd,
                                                        logic [BitsPerByte-1:0] byte_in,
                                                        logic level);
      rsp_payload_type beat;
      logic            drive;
      logic            busy;
      logic            done;
      drive = 1'b0;
      done  = 1'b0;

      // A command is taken only while idle; its own tick is the first of the command.
      if (bus_phase == PH_IDLE && cmd != FUNC_NONE) begin
         tick_cnt = '0;
         bit_pos  = '0;
         case (cmd)
            FUNC_RESET: bus_phase = PH_RST_LOW;
            FUNC_WRITE: begin
               shift_reg = byte_in;
               bus_phase = PH_WR_SLOT;
            end
            default: begin
               shift_reg = '0;
               bus_phase = PH_RD_LOW;
            end
         endcase
      end
      busy = (bus_phase != PH_IDLE);

      case (bus_phase)
         PH_IDLE: ;
         PH_RST_LOW: begin
            drive = 1'b1;
            if (stage_done(reset_low_len)) begin
               bus_phase = PH_RST_WAIT;
               tick_cnt  = '0;
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         PH_RST_WAIT: begin
            // The line is sampled on the tick after the wait; a low level means a device.
            if (tick_cnt < presence_wait_len) begin
               tick_cnt = tick_cnt + 1'b1;
            end else begin
               device_seen = !level;
               tick_cnt    = '0;
               if (device_seen && recovery_len != '0) begin
                  bus_phase = PH_RST_REC;
               end else begin
                  end_command();
                  done = 1'b1;
               end
            end
         end
         PH_RST_REC: begin
            if (stage_done(recovery_len)) begin
               end_command();
               done = 1'b1;
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         PH_WR_SLOT: begin
            // A one bit is low only for the short pulse, unless that covers the slot.
            drive = !shift_reg[0] || (tick_cnt < short_low_len);
            if (stage_done(slot_len)) begin
               tick_cnt = '0;
               if (gap_len != '0) begin
                  bus_phase = PH_WR_GAP;
               end else if (next_bit()) begin
                  end_command();
                  done = 1'b1;
               end else begin
                  shift_reg = shift_reg >> 1;
               end
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         PH_WR_GAP: begin
            if (stage_done(gap_len)) begin
               if (next_bit()) begin
                  end_command();
                  done = 1'b1;
               end else begin
                  shift_reg = shift_reg >> 1;
                  bus_phase = PH_WR_SLOT;
               end
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         PH_RD_LOW: begin
            drive = 1'b1;
            if (stage_done(short_low_len)) begin
               bus_phase = PH_RD_REST;
               tick_cnt  = '0;
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         PH_RD_REST: begin
            // The bit is sampled on the first released tick and enters from the top.
            if (tick_cnt == '0) begin
               shift_reg = {level, shift_reg[BitsPerByte-1:1]};
            end
            if (stage_done(slot_len)) begin
               if (next_bit()) begin
                  read_byte = shift_reg;
                  end_command();
                  done = 1'b1;
               end else begin
                  bus_phase = PH_RD_LOW;
               end
            end else begin
               tick_cnt = tick_cnt + 1'b1;
            end
         end
         default: begin
            end_command();
            busy = 1'b0;
         end
      endcase

      beat.drive_low = drive;
      beat.busy_res  = busy;
      beat.done_res  = done;
      beat.presence  = device_seen;
      beat.read_data = read_byte;
      return beat;
   endfunction

   function automatic void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // Register writes, returned beats and accepted ticks, all seen at the rising edge.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         reset_low_len     = ResetLowDefault;
         presence_wait_len = PresenceWaitDefault;
         recovery_len      = ResetRecoveryDefault;
         slot_len          = SlotDefault;
         gap_len           = GapDefault;
         short_low_len     = ShortLowDefault;
         bus_phase         = PH_IDLE;
         tick_cnt          = '0;
         bit_pos           = '0;
         shift_reg         = '0;
         read_byte         = '0;
         device_seen       = 1'b0;
         mismatch_count    = 0;
         awaited_beats.delete();
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_RESET_LOW:     reset_low_len     = csr_wdata;
               REG_PRESENCE_WAIT: presence_wait_len = csr_wdata;
               REG_RESET_REC:     recovery_len      = csr_wdata;
               REG_SLOT:          slot_len          = csr_wdata;
               REG_GAP:           gap_len           = csr_wdata;
               REG_SHORT_LOW:     short_low_len     = csr_wdata;
               default: ;
            endcase
         end

         // A returned beat always belongs to an earlier tick, so it is checked first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_beats.size() == 0) begin
               mismatch_count++;
               $display("%0t: result beat with none awaited, expected none, got %h",
                        $time, {rsp_mon.drive_low, rsp_mon.busy_res, rsp_mon.done_res,
                                rsp_mon.presence, rsp_mon.read_data});
            end else begin
               want = awaited_beats.pop_front();
               compare_field("drive_low", want.drive_low, rsp_mon.drive_low);
               compare_field("busy_res", want.busy_res, rsp_mon.busy_res);
               compare_field("done_res", want.done_res, rsp_mon.done_res);
               compare_field("presence", want.presence, rsp_mon.presence);
               compare_field("read_data", want.read_data, rsp_mon.read_data);
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            awaited_beats.push_back(bus_tick_outcome(func_type'(req_mon.func), req_mon.data,
                                                     req_mon.line_level));
         end
      end
      pending_count = awaited_beats.size();
      bus_idle      = (bus_phase == PH_IDLE);
   end

endmodule

/* test/onewire_bus_master_tb.sv */
// Testbench top for the single-wire bus master: clock, reset, bus tick stimulus,
// timing register writes and the verdict. Depends on owb_pkg, owb_req_if,
// owb_rsp_if, onewire_bus_master and onewire_bus_master_checker.
module onewire_bus_master_tb;
   import owb_pkg::*;

   // How the sampled line level is chosen during a command
   localparam int LineHigh   = 0;
   localparam int LineLow    = 1;
   localparam int LineRandom = 2;

   // Receiver hold-off length, and ticks of random traffic per phase
   localparam int unsigned HoldCycles  = 40;
   localparam int unsigned PhaseTicks  = 60;
   localparam int unsigned PhaseCount  = 12;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [2:0]           csr_index;
   logic [TickWidth-1:0] csr_wdata;

   int unsigned mismatch_count;
   int unsigned pending_count;
   logic        bus_idle;

   int unsigned send_gap_pct;
   int unsigned stall_pct;
   int unsigned hold_requests;
   int unsigned tick_total;

   owb_req_if req_ch ();
   owb_rsp_if rsp_ch ();

   onewire_bus_master dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   onewire_bus_master_checker bus_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .bus_idle       (bus_idle)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Overall time limit, far beyond the slowest correct run.
   initial begin
      #12_000_000;
      $display("Verification failed");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      int unsigned holds_done;
      int unsigned hold_left;
      holds_done   = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_done != hold_requests) begin
            hold_left = HoldCycles;
            holds_done++;
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic logic pick_level(int line_mode);
      if (line_mode == LineHigh) begin
         return 1'b1;
      end
      if (line_mode == LineLow) begin
         return 1'b0;
      end
      return 1'($urandom_range(1));
   endfunction

   // Mostly very short stages, now and then a longer one.
   function automatic logic [TickWidth-1:0] pick_len();
      if ($urandom_range(9) == 0) begin
         return TickWidth'($urandom_range(24));
      end
      return TickWidth'($urandom_range(3));
   endfunction

   // Offers one tick beat, after random idle cycles, and returns once it is taken.
   task automatic send_tick(input func_type cmd, input logic [BitsPerByte-1:0] byte_val,
                            input logic level);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= cmd;
      req_ch.data       <= byte_val;
      req_ch.line_level <= level;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      tick_total++;
   endtask

   // Issues a command and keeps the ticks coming until it is over; stray commands
   // sent meanwhile must be ignored by the block.
   task automatic run_command(input func_type cmd, input logic [BitsPerByte-1:0] byte_val,
                              input int line_mode, input int unsigned noise_pct);
      func_type stray;
      send_tick(cmd, byte_val, pick_level(line_mode));
      while (!bus_idle) begin
         stray = ($urandom_range(99) < noise_pct) ? func_type'($urandom_range(1, 3)) : FUNC_NONE;
         send_tick(stray, BitsPerByte'($urandom), pick_level(line_mode));
      end
   endtask

   // Holds the input off until every awaited result beat has come back.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // Rewrites all timing registers once the block has gone quiet.
   task automatic set_timing(input logic [TickWidth-1:0] low_len, wait_len, rec_len,
                             slot_len, gap_len, short_len);
      reg_index_type        reg_ids [6] = '{REG_RESET_LOW, REG_PRESENCE_WAIT, REG_RESET_REC,
                                            REG_SLOT, REG_GAP, REG_SHORT_LOW};
      logic [TickWidth-1:0] reg_vals [6];
      reg_vals = '{low_len, wait_len, rec_len, slot_len, gap_len, short_len};
      wait_for_results();
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= reg_ids[i];
         csr_wdata <= reg_vals[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned phase_start;
      int          line_mode;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = REG_RESET_LOW;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_NONE;
      req_ch.data       = '0;
      req_ch.line_level = 1'b1;
      send_gap_pct      = 0;
      stall_pct         = 0;
      hold_requests     = 0;
      tick_total        = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Timing after reset: one byte written with both bit values.
      run_command(FUNC_WRITE, 8'hA5, LineRandom, 30);

      // Shortest legal stages, recovery and gap skipped.
      set_timing(10'd1, 10'd1, 10'd0, 10'd1, 10'd0, 10'd1);
      run_command(FUNC_RESET, 8'h00, LineLow, 0);
      run_command(FUNC_RESET, 8'h00, LineHigh, 0);
      run_command(FUNC_WRITE, 8'h5A, LineRandom, 0);
      run_command(FUNC_READ, 8'h00, LineRandom, 50);

      // All lengths zero: each stage acts as a single tick or is skipped.
      set_timing(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      run_command(FUNC_RESET, 8'h00, LineLow, 0);
      run_command(FUNC_WRITE, 8'hA5, LineRandom, 50);
      run_command(FUNC_READ, 8'h00, LineRandom, 0);

      // Short pulse longer than the slot: a one bit is driven low like a zero bit.
      set_timing(10'd2, 10'd1, 10'd1, 10'd3, 10'd1, 10'd5);
      run_command(FUNC_WRITE, 8'hFF, LineRandom, 0);
      run_command(FUNC_READ, 8'h00, LineRandom, 0);

      // Random phases, each with its own timing and idling pattern.
      for (int phase_no = 0; phase_no < PhaseCount; phase_no++) begin
         set_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
         case (phase_no % 4)
            0: begin
               send_gap_pct = 0;
               stall_pct    = 0;
            end
            1: begin
               send_gap_pct = 87;
               stall_pct    = 0;
            end
            2: begin
               send_gap_pct = 0;
               stall_pct    = 87;
            end
            default: begin
               send_gap_pct = 26;
               stall_pct    = 26;
            end
         endcase
         // The receiver holds off while ticks keep arriving, so the input must stall.
         if (phase_no == 4) begin
            hold_requests++;
         end
         phase_start = tick_total;
         while (tick_total - phase_start < PhaseTicks) begin
            repeat ($urandom_range(2)) begin
               send_tick(FUNC_NONE, BitsPerByte'($urandom), 1'($urandom_range(1)));
            end
            case ($urandom_range(4))
               0:       line_mode = LineLow;
               1:       line_mode = LineHigh;
               default: line_mode = LineRandom;
            endcase
            run_command(func_type'($urandom_range(1, 3)), BitsPerByte'($urandom), line_mode,
                        $urandom_range(20));
            if (phase_no == 5 && $urandom_range(3) == 0) begin
               wait_for_results();
            end
         end
      end

      wait_for_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
